>>> rtl/i2ra_pkg.sv
package i2ra_pkg;

  // Operand and digit geometry
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W = 8;
  // Divider bits retired per cycle
  localparam int unsigned STEPS_PER_CYCLE = 8;

  localparam logic [RADIX_W-1:0] BASE_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX = 5'd16;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  typedef enum logic [1:0] {
    OP_U16 = 2'd0,
    OP_U8  = 2'd1,
    OP_S8  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PRIME,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               upper_case;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div;
    logic prime;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
    logic ptr_zero;
  } sts_t;

  // Map a digit to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic up);
    logic [CHAR_W-1:0] r;
    if (d < DIGIT_TEN) begin
      r = CH_ZERO + {4'd0, d};
    end else begin
      r = (up ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d - DIGIT_TEN};
    end
    return r;
  endfunction

endpackage

>>> rtl/integer_to_radix_ascii.sv
// After an item is taken the divider works out its digits; then the sign, if any, is
// shown in the prime state and the digits follow, most significant first, one
// character each cycle. A new item is taken only once its last character is out; the
// divider retires eight quotient bits a cycle and the emit stage does one read a cycle.
// Reset is asynchronous and active low; it returns the block to idle, dropping any item.
// Results carry a strobe only; the receiver cannot stall them.
module integer_to_radix_ascii #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  i2ra_pkg::in_t  in_i,
  output logic           busy_o,
  output logic           strobe_o,
  output i2ra_pkg::out_t out_o
);

  i2ra_pkg::cmd_t cmd;
  i2ra_pkg::sts_t sts;

  i2ra_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  i2ra_datapath #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .strobe_o(strobe_o),
    .out_o   (out_o)
  );

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy_o)
    else $error("result while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item left no work");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && out_o.last) |=> !strobe_o)
    else $error("result straight after last character");

endmodule

>>> rtl/i2ra_ram.sv
module i2ra_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/i2ra_datapath.sv
module i2ra_datapath #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  i2ra_pkg::in_t  in_i,
  input  i2ra_pkg::cmd_t cmd_i,
  output i2ra_pkg::sts_t sts_o,
  output logic           strobe_o,
  output i2ra_pkg::out_t out_o
);

  localparam int unsigned AW = $clog2(MAX_DIGITS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_DIGITS - 1);

  logic [i2ra_pkg::VALUE_W-1:0] dvd_q, dvd_d;
  logic [i2ra_pkg::DIGIT_W-1:0] rem_q, rem_d;
  logic [i2ra_pkg::RADIX_W-1:0] base_q, base_d;
  logic                         neg_q, neg_d;
  logic                         upper_q;
  logic                         phase_q;
  logic [AW-1:0]                cnt_q;
  logic [i2ra_pkg::VALUE_W-1:0] mag;
  logic [i2ra_pkg::VALUE_W-1:0] step_dvd;
  logic [i2ra_pkg::DIGIT_W-1:0] step_rem;
  logic                         digit_end;
  logic                         conv_end;
  logic [AW-1:0]                raddr;
  logic [i2ra_pkg::DIGIT_W-1:0] rdata;

  // Decode the type mode into magnitude and sign, clamp the base
  always_comb begin
    mag = in_i.value;
    neg_d = 1'b0;
    unique case (i2ra_pkg::op_e'(in_i.op))
      i2ra_pkg::OP_U8: begin
        mag = {8'd0, in_i.value[7:0]};
      end
      i2ra_pkg::OP_S8: begin
        if (in_i.value[7]) begin
          neg_d = 1'b1;
          mag = {8'd0, (~in_i.value[7:0]) + 8'd1};
        end else begin
          mag = {8'd0, in_i.value[7:0]};
        end
      end
      default: begin
        mag = in_i.value;
      end
    endcase
    if (in_i.radix < i2ra_pkg::BASE_MIN) begin
      base_d = i2ra_pkg::BASE_MIN;
    end else if (in_i.radix > i2ra_pkg::BASE_MAX) begin
      base_d = i2ra_pkg::BASE_MAX;
    end else begin
      base_d = in_i.radix;
    end
  end

  // Restoring division, eight quotient bits per cycle
  always_comb begin
    logic [i2ra_pkg::DIGIT_W:0] part;
    logic [i2ra_pkg::DIGIT_W:0] diff;
    logic                       qbit;
    step_dvd = dvd_q;
    step_rem = phase_q ? rem_q : '0;
    for (int i = 0; i < int'(i2ra_pkg::STEPS_PER_CYCLE); i++) begin
      part = {step_rem, step_dvd[i2ra_pkg::VALUE_W-1]};
      diff = part - base_q;
      qbit = (part >= base_q);
      step_rem = qbit ? diff[i2ra_pkg::DIGIT_W-1:0] : part[i2ra_pkg::DIGIT_W-1:0];
      step_dvd = {step_dvd[i2ra_pkg::VALUE_W-2:0], qbit};
    end
  end

  // Stop on a zero quotient or when the digit store is full
  assign digit_end = cmd_i.div & phase_q;
  assign conv_end = (step_dvd == '0) || (cnt_q == LAST_SLOT);

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      dvd_d = mag;
    end else if (cmd_i.div) begin
      dvd_d = step_dvd;
      rem_d = step_rem;
    end
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (cmd_i.load) begin
      base_q <= base_d;
      neg_q <= neg_d;
      upper_q <= in_i.upper_case;
    end
  end

  // Half-digit phase and digit pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      phase_q <= 1'b0;
      cnt_q <= '0;
    end else if (cmd_i.div) begin
      phase_q <= ~phase_q;
      if (phase_q && !conv_end) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else if (cmd_i.emit) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Read the top digit on prime, then step down one a cycle
  assign raddr = cmd_i.prime ? cnt_q : cnt_q - 1'b1;

  i2ra_ram #(
    .WIDTH(i2ra_pkg::DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (digit_end),
    .waddr_i(cnt_q),
    .wdata_i(step_rem),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign sts_o.div_last = digit_end & conv_end;
  assign sts_o.ptr_zero = (cnt_q == '0);

  // Sign on prime, digits on emit
  assign strobe_o = (cmd_i.prime & neg_q) | cmd_i.emit;
  always_comb begin
    out_o.char_out = cmd_i.prime ? i2ra_pkg::CH_MINUS
                                 : i2ra_pkg::digit_char(rdata, upper_q);
    out_o.last = cmd_i.emit & (cnt_q == '0);
  end

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_end |-> (cnt_q <= LAST_SLOT))
    else $error("digit write beyond store");

endmodule

>>> rtl/i2ra_ctrl.sv
module i2ra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  i2ra_pkg::sts_t sts_i,
  output i2ra_pkg::cmd_t cmd_o,
  output logic           busy_o
);

  i2ra_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2ra_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      i2ra_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = i2ra_pkg::ST_DIV;
        end
      end
      i2ra_pkg::ST_DIV: begin
        cmd_o.div = 1'b1;
        if (sts_i.div_last) begin
          state_d = i2ra_pkg::ST_PRIME;
        end
      end
      i2ra_pkg::ST_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d = i2ra_pkg::ST_EMIT;
      end
      i2ra_pkg::ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.ptr_zero) begin
          state_d = i2ra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = i2ra_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != i2ra_pkg::ST_IDLE);

endmodule

>>> tb/sv/i2ra_checker.sv
module i2ra_checker #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  i2ra_pkg::in_t         item_i,
  input  logic                  strobe_i,
  input  i2ra_pkg::out_t        char_i,
  output int unsigned           mismatches_o,
  output int unsigned           chars_due_o
);

  // Longest string a single item may print
  localparam int RESULT_LIMIT = 16;

  i2ra_pkg::out_t chars_due_q[$];
  i2ra_pkg::out_t oldest;
  int unsigned    mismatches_q = 0;

  assign mismatches_o = mismatches_q;
  assign chars_due_o  = chars_due_q.size();

  // Turn one digit value into its ASCII glyph
  function automatic logic [i2ra_pkg::CHAR_W-1:0] glyph(
      input logic [i2ra_pkg::DIGIT_W-1:0] d, input logic up);
    return (d < i2ra_pkg::DIGIT_TEN) ? i2ra_pkg::CH_ZERO + {4'd0, d}
         : (up ? i2ra_pkg::CH_UPPER_A : i2ra_pkg::CH_LOWER_A)
           + {4'd0, d - i2ra_pkg::DIGIT_TEN};
  endfunction

  // Work out the characters one item prints and queue them in order
  function automatic void spell_number(input i2ra_pkg::in_t item);
    int unsigned                  base;
    int unsigned                  mag;
    int unsigned                  rem;
    logic                         neg;
    logic [i2ra_pkg::DIGIT_W-1:0] digits [MAX_DIGITS];
    int                           nd;
    int                           total;
    int                           k;
    i2ra_pkg::out_t               ch;
    base = 32'(item.radix);
    neg  = 1'b0;
    nd   = 0;
    k    = 0;
    // Clamp the base into 2..16
    if (base < i2ra_pkg::BASE_MIN) base = 32'(i2ra_pkg::BASE_MIN);
    if (base > i2ra_pkg::BASE_MAX) base = 32'(i2ra_pkg::BASE_MAX);
    // Pick the magnitude by type mode; unused mode falls back to 16-bit
    case (item.op)
      i2ra_pkg::OP_U8: mag = 32'(item.value[7:0]);
      i2ra_pkg::OP_S8: begin
        if (item.value[7]) begin
          neg = 1'b1;
          mag = 32'd256 - 32'(item.value[7:0]);
        end else begin
          mag = 32'(item.value[7:0]);
        end
      end
      default: mag = 32'(item.value);
    endcase
    // Divide down, least significant digit first
    if (mag == 0) begin
      digits[0] = '0;
      nd = 1;
    end else begin
      while (mag != 0 && nd < int'(MAX_DIGITS)) begin
        rem = mag % base;
        digits[nd] = rem[i2ra_pkg::DIGIT_W-1:0];
        mag = mag / base;
        nd++;
      end
    end
    total = nd + int'(neg);
    if (total > RESULT_LIMIT) begin
      nd -= total - RESULT_LIMIT;
      total = RESULT_LIMIT;
    end
    // Sign first, then digits most significant first
    if (neg) begin
      ch.char_out = i2ra_pkg::CH_MINUS;
      ch.last = (k + 1 == total);
      chars_due_q.push_back(ch);
      k++;
    end
    for (int i = nd - 1; i >= 0; i--) begin
      ch.char_out = glyph(digits[i], item.upper_case);
      ch.last = (k + 1 == total);
      chars_due_q.push_back(ch);
      k++;
    end
  endfunction

  // Compare each strobed character with the oldest one due, then queue new items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_i) begin
        if (chars_due_q.size() == 0) begin
          $error("char_out 0x%02h last %0b arrived with nothing due", char_i.char_out,
                 char_i.last);
          mismatches_q++;
        end else begin
          oldest = chars_due_q.pop_front();
          if (char_i.char_out !== oldest.char_out) begin
            $error("char_out: expected 0x%02h, actual 0x%02h", oldest.char_out,
                   char_i.char_out);
            mismatches_q++;
          end
          if (char_i.last !== oldest.last) begin
            $error("last: expected %0b, actual %0b", oldest.last, char_i.last);
            mismatches_q++;
          end
        end
      end
      if (start_i && !busy_i) begin
        spell_number(item_i);
      end
    end
  end

endmodule

>>> tb/sv/tb_integer_to_radix_ascii.sv
module tb_integer_to_radix_ascii;

  localparam int unsigned DIGIT_DEPTH  = 16;
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned DRAIN_EVERY  = 100;
  localparam int unsigned SETTLE_CYCLES = 64;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start_i;
  i2ra_pkg::in_t  in_i;
  logic           busy_o;
  logic           strobe_o;
  i2ra_pkg::out_t out_o;
  int unsigned    mismatches;
  int unsigned    chars_due;

  integer_to_radix_ascii #(
    .MAX_DIGITS (DIGIT_DEPTH)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .in_i     (in_i),
    .busy_o   (busy_o),
    .strobe_o (strobe_o),
    .out_o    (out_o)
  );

  i2ra_checker #(
    .MAX_DIGITS (DIGIT_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .item_i       (in_i),
    .strobe_i     (strobe_o),
    .char_i       (out_o),
    .mismatches_o (mismatches),
    .chars_due_o  (chars_due)
  );

  // Clock: 20 units per period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abandon a hung run
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic i2ra_pkg::in_t make_item(input logic [1:0] op,
                                              input logic [i2ra_pkg::VALUE_W-1:0] value,
                                              input logic [i2ra_pkg::RADIX_W-1:0] radix,
                                              input logic up);
    i2ra_pkg::in_t it;
    it.op = op;
    it.value = value;
    it.radix = radix;
    it.upper_case = up;
    return it;
  endfunction

  // Draw a random item, biased towards small and extreme values
  function automatic i2ra_pkg::in_t random_item();
    i2ra_pkg::in_t it;
    int unsigned   pick;
    pick = $urandom_range(0, 9);
    it.op = (pick < 3) ? i2ra_pkg::OP_U16 : (pick < 6) ? i2ra_pkg::OP_U8 :
            (pick < 9) ? i2ra_pkg::OP_S8 : OP_SPARE;
    case ($urandom_range(0, 7))
      0: it.value = 16'($urandom_range(0, 3));
      1: begin
        case ($urandom_range(0, 5))
          0: it.value = 16'h0000;
          1: it.value = 16'hFFFF;
          2: it.value = 16'h0080;
          3: it.value = 16'h007F;
          4: it.value = 16'h8000;
          default: it.value = 16'h00FF;
        endcase
      end
      default: it.value = 16'($urandom);
    endcase
    it.radix = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(2, 16));
    it.upper_case = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Hold the item on the inputs until the block takes it
  task automatic offer(input i2ra_pkg::in_t item);
    start_i <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start for a number of cycles
  task automatic pause(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Drop start until every due character has arrived
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (chars_due != 0);
  endtask

  initial begin
    i2ra_pkg::in_t directed[$];
    int unsigned   sent;
    int unsigned   burst;
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, extremes, every mode, sign corner, clamped bases
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'h0000, 5'd10, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'hFFFF, 5'd2, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'hFFFF, 5'd16, 1'b1));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'hABCD, 5'd16, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'hABCD, 5'd16, 1'b1));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'h8000, 5'd10, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'hFFFF, 5'd3, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U8, 16'h00FF, 5'd2, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U8, 16'hFF00, 5'd10, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U8, 16'h55FE, 5'd16, 1'b1));
    directed.push_back(make_item(i2ra_pkg::OP_S8, 16'h0080, 5'd10, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_S8, 16'h0080, 5'd2, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_S8, 16'hFFFF, 5'd16, 1'b1));
    directed.push_back(make_item(i2ra_pkg::OP_S8, 16'h007F, 5'd10, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_S8, 16'hFF00, 5'd7, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_S8, 16'h00C5, 5'd13, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'h00FF, 5'd0, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'h00FF, 5'd1, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'hBEEF, 5'd17, 1'b0));
    directed.push_back(make_item(i2ra_pkg::OP_U16, 16'hBEEF, 5'd31, 1'b1));
    directed.push_back(make_item(OP_SPARE, 16'hF234, 5'd16, 1'b0));
    directed.push_back(make_item(OP_SPARE, 16'h0000, 5'd2, 1'b1));
    foreach (directed[i]) begin
      offer(directed[i]);
      if (i % 4 == 3) pause($urandom_range(1, 40));
    end
    drain();

    // Random: bursts of back-to-back items with gaps of assorted length
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < RANDOM_ITEMS) begin
          offer(random_item());
          sent++;
          if (sent % DRAIN_EVERY == 0) drain();
        end
      end
      case ($urandom_range(0, 3))
        0: ;
        1: pause($urandom_range(1, 60));
        default: pause($urandom_range(1, 4));
      endcase
    end

    // Wait for the tail and settle
    start_i <= 1'b0;
    do @(posedge clk_i); while (chars_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && chars_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
